[src/esu_pkg.sv]
`default_nettype none

package esu_pkg;

	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned QDEPTH  = 8;
	localparam int unsigned PTR_W   = $clog2(QDEPTH);
	localparam int unsigned CNT_W   = $clog2(QDEPTH + 1);
	localparam int unsigned NRES_W  = $clog2(MAX_RES + 1);

	localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
	localparam logic [UNIT_W-1:0] CH_N      = 16'h006E;
	localparam logic [UNIT_W-1:0] CH_R      = 16'h0072;
	localparam logic [UNIT_W-1:0] CH_T      = 16'h0074;
	localparam logic [UNIT_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [UNIT_W-1:0] CH_X      = 16'h0078;
	localparam logic [UNIT_W-1:0] CH_LF     = 16'h000A;
	localparam logic [UNIT_W-1:0] CH_CR     = 16'h000D;
	localparam logic [UNIT_W-1:0] CH_TAB    = 16'h0009;
	localparam logic [UNIT_W-1:0] CH_NUL    = 16'h0000;

	typedef enum logic [3:0] {
		STG_PLAIN = 4'b0001,
		STG_BSL   = 4'b0010,
		STG_X     = 4'b0100,
		STG_DIG   = 4'b1000
	} stage_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              last;
	} res_t;

	function automatic logic is_hex(input logic [UNIT_W-1:0] c);
		return (c >= 16'h0030 && c <= 16'h0039) ||
		       (c >= 16'h0041 && c <= 16'h0046) ||
		       (c >= 16'h0061 && c <= 16'h0066);
	endfunction

	// nibble value of a unit already known to be a hex digit
	function automatic logic [3:0] hex_nib(input logic [UNIT_W-1:0] c);
		logic [3:0] v;
		if (c <= 16'h0039) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[src/escape_sequence_unescaper_core.sv]
// Accepted items' results are registered in the result queue. Throughput: one
// item per cycle while in_ready is high; an item yields zero to four results,
// drained one per cycle while out_ready is high; the queue holds eight. Input
// ready needs room for four results, so bursts of escape failures set the rate.
// Reset (arst_n low, asynchronous): no escape pending, queue empty.
`default_nettype none

module escape_sequence_unescaper_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [esu_pkg::UNIT_W-1:0]    code_unit,
	input  wire                          end_of_text,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [esu_pkg::UNIT_W-1:0]   out_unit,
	output logic                         out_last
);

	import esu_pkg::*;

	stage_t             stage_q, stage_d;
	logic [UNIT_W-1:0]  held_q, held_d;
	logic [UNIT_W-1:0]  res_unit [MAX_RES];
	logic [NRES_W-1:0]  n_res;
	logic [NRES_W-1:0]  push_n;

	res_t               queue_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               in_acc, out_acc;

	assign in_ready  = (count_q <= CNT_W'(QDEPTH - MAX_RES));
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign out_acc   = out_valid && out_ready;
	assign out_unit  = queue_q[rd_ptr_q].unit;
	assign out_last  = queue_q[rd_ptr_q].last;
	assign push_n    = in_acc ? n_res : '0;

	always_comb begin
		logic [7:0] byte_v;
		byte_v  = {hex_nib(held_q), hex_nib(code_unit)};
		stage_d = stage_q;
		held_d  = held_q;
		n_res   = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_unit[i] = code_unit;
		end
		case (stage_q)
			STG_PLAIN: begin
				if (code_unit == CH_BSLASH && !end_of_text) begin
					stage_d = STG_BSL;
				end else begin
					n_res = NRES_W'(1);
				end
			end
			STG_BSL: begin
				stage_d = STG_PLAIN;
				n_res   = NRES_W'(1);
				case (code_unit)
					CH_N:      res_unit[0] = CH_LF;
					CH_R:      res_unit[0] = CH_CR;
					CH_T:      res_unit[0] = CH_TAB;
					CH_ZERO:   res_unit[0] = CH_NUL;
					CH_BSLASH: res_unit[0] = CH_BSLASH;
					CH_X: begin
						if (end_of_text) begin
							res_unit[0] = CH_BSLASH;
							res_unit[1] = CH_X;
							n_res       = NRES_W'(2);
						end else begin
							stage_d = STG_X;
							n_res   = '0;
						end
					end
					default: begin
						res_unit[0] = CH_BSLASH;
						n_res       = NRES_W'(2);
					end
				endcase
			end
			STG_X: begin
				if (is_hex(code_unit) && !end_of_text) begin
					held_d  = code_unit;
					stage_d = STG_DIG;
				end else begin
					res_unit[0] = CH_BSLASH;
					res_unit[1] = CH_X;
					// failing unit rescanned from the plain state
					if (code_unit == CH_BSLASH && !end_of_text) begin
						stage_d = STG_BSL;
						n_res   = NRES_W'(2);
					end else begin
						stage_d = STG_PLAIN;
						n_res   = NRES_W'(3);
					end
				end
			end
			STG_DIG: begin
				held_d = '0;
				if (is_hex(code_unit)) begin
					res_unit[0] = {8'h00, byte_v};
					stage_d     = STG_PLAIN;
					n_res       = NRES_W'(1);
				end else begin
					res_unit[0] = CH_BSLASH;
					res_unit[1] = CH_X;
					res_unit[2] = held_q;
					if (code_unit == CH_BSLASH && !end_of_text) begin
						stage_d = STG_BSL;
						n_res   = NRES_W'(3);
					end else begin
						stage_d = STG_PLAIN;
						n_res   = NRES_W'(4);
					end
				end
			end
			default: begin
				stage_d = STG_PLAIN;
			end
		endcase
		if (end_of_text) begin
			stage_d = STG_PLAIN;
			held_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= STG_PLAIN;
			held_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				stage_q <= stage_d;
				held_q  <= held_d;
			end
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (NRES_W'(i) < push_n) begin
				queue_q[wr_ptr_q + PTR_W'(i)].unit <= res_unit[i];
				queue_q[wr_ptr_q + PTR_W'(i)].last <=
					end_of_text && (NRES_W'(i + 1) == push_n);
			end
		end
	end

endmodule

`default_nettype wire

[src/esu_checker.sv]
`default_nettype none

module esu_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        end_of_text,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [esu_pkg::UNIT_W-1:0]  out_unit,
	input wire                        out_last
);

	// the last unit of a text always leaves at least one result queued
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_text |=> out_valid)
		else $error("end of text item gave no result");

	// back-pressure only when results are waiting
	a_stall_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(out_last))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn before accept");

endmodule

bind escape_sequence_unescaper_core esu_checker u_esu_checker (.*);

`default_nettype wire
